FILE: hdl/battery_energy_direction_meter_top_macros.svh
// Assertion macros for the battery energy direction meter.
`ifndef BATTERY_ENERGY_DIRECTION_METER_TOP_MACROS_SVH
`define BATTERY_ENERGY_DIRECTION_METER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is high.
`define BEDM_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("bedm assertion failed");
// Check a property on every rising edge, reset included.
`define BEDM_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) (prop)) \
    else $error("bedm assertion failed");
`else
`define BEDM_ASSERT(lbl, clk_sig, rst_sig, prop)
`define BEDM_ASSERT_ALWAYS(lbl, clk_sig, prop)
`endif
`endif

FILE: hdl/bedm_pkg.sv
// Types and constants shared by the battery energy direction meter.
package bedm_pkg;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 64;
  localparam int ENERGY_W = 41;
  localparam int OUT_W    = 63;

  // Register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_DELTA    = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [19:0] WINDOW_RESET   = 20'd1000;
  localparam logic [47:0] DELTA_RESET    = 48'd3600000000;
  localparam logic [15:0] INTERVAL_RESET = 16'd60;

  // Direction codes as seen on the result
  localparam logic [2:0] DIR_STANDBY    = 3'd0;
  localparam logic [2:0] DIR_CHARGE     = 3'd1;
  localparam logic [2:0] DIR_CHG_TO_DIS = 3'd2;
  localparam logic [2:0] DIR_DISCHARGE  = 3'd3;
  localparam logic [2:0] DIR_DIS_TO_CHG = 3'd4;

  typedef enum logic [4:0] {
    MODE_STANDBY    = 5'b00001,
    MODE_CHARGE     = 5'b00010,
    MODE_CHG_TO_DIS = 5'b00100,
    MODE_DISCHARGE  = 5'b01000,
    MODE_DIS_TO_CHG = 5'b10000
  } mode_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_STANDBY:    c = DIR_STANDBY;
      MODE_CHARGE:     c = DIR_CHARGE;
      MODE_CHG_TO_DIS: c = DIR_CHG_TO_DIS;
      MODE_DISCHARGE:  c = DIR_DISCHARGE;
      MODE_DIS_TO_CHG: c = DIR_DIS_TO_CHG;
      default:         c = DIR_STANDBY;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/battery_energy_direction_meter_top.sv
// Battery energy direction meter: energy totals, direction sessions, save timing.
// Each accepted transaction passes the sample register and then the result register.
// Throughput: one transaction per cycle unless out_ready holds the result; the 21x20 multiply
// sits before the sample register and the saturating adds and save compares before the result register.
// Reset (synchronous, active high) clears totals, sessions, baselines and timing,
// returns the direction machine to standby and reloads the configuration defaults.
`include "battery_energy_direction_meter_top_macros.svh"

module battery_energy_direction_meter_top #(
  parameter int ACC_WIDTH = 63
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bedm_pkg::ADDR_W-1:0]           paddr,
  input  logic [bedm_pkg::DATA_W-1:0]           pwdata,
  output logic [bedm_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic signed [20:0]                    current_ma,
  input  logic [19:0]                           voltage_mv,
  input  logic [31:0]                           time_s,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bedm_pkg::OUT_W-1:0]            total_charge_uj,
  output logic [bedm_pkg::OUT_W-1:0]            total_discharge_uj,
  output logic [bedm_pkg::OUT_W-1:0]            session_charge_uj,
  output logic [bedm_pkg::OUT_W-1:0]            session_discharge_uj,
  output logic [2:0]                            direction_mode,
  output logic                                  save_now
);

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  // Configuration
  logic [19:0] current_window_ma;
  logic [47:0] save_delta_uj;
  logic [15:0] save_interval_s;
  logic        cfg_write;
  logic [1:0]  cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      current_window_ma <= bedm_pkg::WINDOW_RESET;
      save_delta_uj     <= bedm_pkg::DELTA_RESET;
      save_interval_s   <= bedm_pkg::INTERVAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        bedm_pkg::REG_WINDOW:   current_window_ma <= pwdata[19:0];
        bedm_pkg::REG_DELTA:    save_delta_uj     <= pwdata[47:0];
        bedm_pkg::REG_INTERVAL: save_interval_s   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bedm_pkg::REG_WINDOW:   prdata = {44'd0, current_window_ma};
      bedm_pkg::REG_DELTA:    prdata = {16'd0, save_delta_uj};
      bedm_pkg::REG_INTERVAL: prdata = {48'd0, save_interval_s};
      default:                prdata = '0;
    endcase
  end

  // Sample stage: magnitude, energy product and window flags
  logic                          s1_valid;
  logic                          s1_cmd;
  logic                          s1_pos;
  logic                          s1_above;
  logic                          s1_below;
  logic [bedm_pkg::ENERGY_W-1:0] s1_energy;
  logic [31:0]                   s1_time;
  logic                          in_take;
  logic                          load;
  logic signed [21:0]            cur_ext;
  logic signed [21:0]            win_ext;
  logic [21:0]                   mag_w;
  logic [bedm_pkg::ENERGY_W-1:0] energy;

  assign load     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || load;
  assign in_take  = in_valid && in_ready;

  assign cur_ext = 22'(current_ma);
  assign win_ext = $signed({2'b00, current_window_ma});
  assign mag_w   = current_ma[20] ? 22'(-cur_ext) : 22'(cur_ext);
  assign energy  = bedm_pkg::ENERGY_W'(mag_w[20:0]) * bedm_pkg::ENERGY_W'(voltage_mv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd    <= cmd;
      s1_pos    <= cur_ext > 22'sd0;
      s1_above  <= cur_ext > win_ext;
      s1_below  <= cur_ext < -win_ext;
      s1_energy <= energy;
      s1_time   <= time_s;
    end
  end

  // Accumulator state; it also serves as the result register
  logic [ACC_WIDTH-1:0] charge_total, charge_total_next;
  logic [ACC_WIDTH-1:0] discharge_total, discharge_total_next;
  logic [ACC_WIDTH-1:0] charge_session, charge_session_next;
  logic [ACC_WIDTH-1:0] discharge_session, discharge_session_next;
  logic [ACC_WIDTH-1:0] charge_baseline, charge_baseline_next;
  logic [ACC_WIDTH-1:0] discharge_baseline, discharge_baseline_next;
  bedm_pkg::mode_t      mode, mode_next;
  logic                 save_pending, save_pending_next;
  logic [31:0]          last_check_time, last_check_time_next;
  logic                 save_next;
  logic [ACC_WIDTH-1:0] energy_acc;
  logic [31:0]          elapsed;
  logic                 pending_arm;

  function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                   input logic [ACC_WIDTH-1:0] b);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_WIDTH] ? ACC_MAX : s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic grew(input logic [ACC_WIDTH-1:0] total,
                                input logic [ACC_WIDTH-1:0] base,
                                input logic [47:0]          delta);
    logic [ACC_WIDTH-1:0] diff;
    diff = total - base;
    return (total > base) && (diff > ACC_WIDTH'(delta));
  endfunction

  assign energy_acc = ACC_WIDTH'(s1_energy);
  assign elapsed    = s1_time - last_check_time;

  always_comb begin
    charge_total_next       = charge_total;
    discharge_total_next    = discharge_total;
    charge_session_next     = charge_session;
    discharge_session_next  = discharge_session;
    charge_baseline_next    = charge_baseline;
    discharge_baseline_next = discharge_baseline;
    mode_next               = mode;
    save_pending_next       = save_pending;
    last_check_time_next    = last_check_time;
    save_next               = 1'b0;
    pending_arm             = 1'b0;

    if (s1_cmd) begin
      // Force save: latch baselines and clear the pending flag; totals, sessions and direction stay put
      charge_baseline_next    = charge_total;
      discharge_baseline_next = discharge_total;
      save_pending_next       = 1'b0;
      save_next               = 1'b1;
    end else begin
      if (s1_pos) begin
        charge_total_next = sat_add(charge_total, energy_acc);
      end else begin
        discharge_total_next = sat_add(discharge_total, energy_acc);
      end

      unique case (mode)
        bedm_pkg::MODE_STANDBY: begin
          if (s1_above) begin
            mode_next = bedm_pkg::MODE_CHARGE;
          end else if (s1_below) begin
            mode_next = bedm_pkg::MODE_DISCHARGE;
          end
        end
        bedm_pkg::MODE_CHARGE: begin
          if (s1_above) begin
            discharge_session_next = '0;
            charge_session_next    = sat_add(charge_session, energy_acc);
          end else if (s1_below) begin
            mode_next = bedm_pkg::MODE_CHG_TO_DIS;
          end else begin
            mode_next = bedm_pkg::MODE_STANDBY;
          end
        end
        bedm_pkg::MODE_CHG_TO_DIS: mode_next = bedm_pkg::MODE_DISCHARGE;
        bedm_pkg::MODE_DISCHARGE: begin
          if (s1_below) begin
            charge_session_next    = '0;
            discharge_session_next = sat_add(discharge_session, energy_acc);
          end else if (s1_above) begin
            mode_next = bedm_pkg::MODE_DIS_TO_CHG;
          end else begin
            mode_next = bedm_pkg::MODE_STANDBY;
          end
        end
        bedm_pkg::MODE_DIS_TO_CHG: mode_next = bedm_pkg::MODE_CHARGE;
        default:                   mode_next = bedm_pkg::MODE_STANDBY;
      endcase

      pending_arm = grew(charge_total_next, charge_baseline, save_delta_uj) ||
                    grew(discharge_total_next, discharge_baseline, save_delta_uj);
      save_pending_next = save_pending || pending_arm;

      if (elapsed > 32'(save_interval_s)) begin
        if (save_pending_next) begin
          charge_baseline_next    = charge_total_next;
          discharge_baseline_next = discharge_total_next;
          save_pending_next       = 1'b0;
          save_next               = 1'b1;
        end
        last_check_time_next = s1_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_total       <= '0;
      discharge_total    <= '0;
      charge_session     <= '0;
      discharge_session  <= '0;
      charge_baseline    <= '0;
      discharge_baseline <= '0;
      mode               <= bedm_pkg::MODE_STANDBY;
      save_pending       <= 1'b0;
      last_check_time    <= '0;
      save_now           <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (load) begin
        charge_total       <= charge_total_next;
        discharge_total    <= discharge_total_next;
        charge_session     <= charge_session_next;
        discharge_session  <= discharge_session_next;
        charge_baseline    <= charge_baseline_next;
        discharge_baseline <= discharge_baseline_next;
        mode               <= mode_next;
        save_pending       <= save_pending_next;
        last_check_time    <= last_check_time_next;
        save_now           <= save_next;
      end
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  assign total_charge_uj      = bedm_pkg::OUT_W'(charge_total);
  assign total_discharge_uj   = bedm_pkg::OUT_W'(discharge_total);
  assign session_charge_uj    = bedm_pkg::OUT_W'(charge_session);
  assign session_discharge_uj = bedm_pkg::OUT_W'(discharge_session);
  assign direction_mode       = bedm_pkg::mode_code(mode);

  `BEDM_ASSERT(a_cd_to_dis, clk, rst, (load && !s1_cmd && mode == bedm_pkg::MODE_CHG_TO_DIS) |=> (mode == bedm_pkg::MODE_DISCHARGE))
  `BEDM_ASSERT(a_chg_clears_dis, clk, rst, (load && !s1_cmd && mode == bedm_pkg::MODE_CHARGE && s1_above) |=> (discharge_session == '0))
  `BEDM_ASSERT(a_save_baseline, clk, rst, (out_valid && save_now) |-> (charge_baseline == charge_total && discharge_baseline == discharge_total))
  `BEDM_ASSERT(a_total_monotonic, clk, rst, load |=> (charge_total >= $past(charge_total) && discharge_total >= $past(discharge_total)))
  `BEDM_ASSERT_ALWAYS(a_ready_free, clk, (!s1_valid) |-> in_ready)

endmodule

FILE: bench/bedm_result_checker.sv
// Result checker for the battery energy direction meter: predicts each result and compares it.
module bedm_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [bedm_pkg::ADDR_W-1:0]   paddr,
  input  logic [bedm_pkg::DATA_W-1:0]   pwdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [20:0]            current_ma,
  input  logic [19:0]                   voltage_mv,
  input  logic [31:0]                   time_s,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bedm_pkg::OUT_W-1:0]    total_charge_uj,
  input  logic [bedm_pkg::OUT_W-1:0]    total_discharge_uj,
  input  logic [bedm_pkg::OUT_W-1:0]    session_charge_uj,
  input  logic [bedm_pkg::OUT_W-1:0]    session_discharge_uj,
  input  logic [2:0]                    direction_mode,
  input  logic                          save_now,
  output int                            pending,
  output int                            errors,
  output int                            checked,
  output int                            saves
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bedm_pkg::OUT_W-1:0] chg_total;
    logic [bedm_pkg::OUT_W-1:0] dis_total;
    logic [bedm_pkg::OUT_W-1:0] chg_session;
    logic [bedm_pkg::OUT_W-1:0] dis_session;
    logic [2:0]                 dir;
    logic                       save;
  } energy_report_t;

  localparam logic [bedm_pkg::OUT_W-1:0] ACC_MAX = '1;

  // register copies
  logic [19:0]                window;
  logic [47:0]                save_delta;
  logic [15:0]                save_interval;

  // meter state
  logic [bedm_pkg::OUT_W-1:0] chg_total, dis_total, chg_session, dis_session;
  logic [bedm_pkg::OUT_W-1:0] chg_base, dis_base;
  logic [2:0]                 dir;
  logic                       save_armed;
  logic [31:0]                last_check;

  energy_report_t             report_q[$];
  int                         n_err  = 0;
  int                         n_chk  = 0;
  int                         n_save = 0;

  function automatic logic [bedm_pkg::OUT_W-1:0] sat_sum(
      input logic [bedm_pkg::OUT_W-1:0] a, input logic [bedm_pkg::OUT_W-1:0] b);
    logic [bedm_pkg::OUT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[bedm_pkg::OUT_W] ? ACC_MAX : s[bedm_pkg::OUT_W-1:0];
  endfunction

  function automatic logic grown(input logic [bedm_pkg::OUT_W-1:0] total,
                                 input logic [bedm_pkg::OUT_W-1:0] base);
    return (total > base) && ((total - base) > {15'd0, save_delta});
  endfunction

  task automatic take_baseline();
    chg_base   = chg_total;
    dis_base   = dis_total;
    save_armed = 1'b0;
  endtask

  task automatic predict_sample(input logic save_cmd, input logic signed [20:0] amps,
                                input logic [19:0] mv, input logic [31:0] now);
    logic signed [21:0]         lim;
    logic [20:0]                mag;
    logic [bedm_pkg::OUT_W-1:0] energy;
    logic                       above, below, fired;
    energy_report_t             r;
    fired = 1'b0;
    if (save_cmd) begin
      take_baseline();
      fired = 1'b1;
    end else begin
      lim    = $signed({2'b00, window});
      above  = amps > lim;
      below  = amps < -lim;
      mag    = amps[20] ? 21'(~amps + 21'd1) : 21'(amps);
      energy = {42'd0, mag} * {43'd0, mv};
      // zero current books as discharge of zero energy
      if (amps > 0) chg_total = sat_sum(chg_total, energy);
      else dis_total = sat_sum(dis_total, energy);
      case (dir)
        bedm_pkg::DIR_STANDBY: begin
          if (above) dir = bedm_pkg::DIR_CHARGE;
          else if (below) dir = bedm_pkg::DIR_DISCHARGE;
        end
        bedm_pkg::DIR_CHARGE: begin
          if (above) begin
            dis_session = '0;
            chg_session = sat_sum(chg_session, energy);
          end else if (below) begin
            dir = bedm_pkg::DIR_CHG_TO_DIS;
          end else begin
            dir = bedm_pkg::DIR_STANDBY;
          end
        end
        bedm_pkg::DIR_CHG_TO_DIS: dir = bedm_pkg::DIR_DISCHARGE;
        bedm_pkg::DIR_DISCHARGE: begin
          if (below) begin
            chg_session = '0;
            dis_session = sat_sum(dis_session, energy);
          end else if (above) begin
            dir = bedm_pkg::DIR_DIS_TO_CHG;
          end else begin
            dir = bedm_pkg::DIR_STANDBY;
          end
        end
        bedm_pkg::DIR_DIS_TO_CHG: dir = bedm_pkg::DIR_CHARGE;
        default: dir = bedm_pkg::DIR_STANDBY;
      endcase
      if (grown(chg_total, chg_base) || grown(dis_total, dis_base)) save_armed = 1'b1;
      // elapsed time is modular, so a wrapped clock still counts forward
      if ((now - last_check) > 32'(save_interval)) begin
        if (save_armed) begin
          take_baseline();
          fired = 1'b1;
        end
        last_check = now;
      end
    end
    r.chg_total   = chg_total;
    r.dis_total   = dis_total;
    r.chg_session = chg_session;
    r.dis_session = dis_session;
    r.dir         = dir;
    r.save        = fired;
    report_q.push_back(r);
  endtask

  function automatic int field_bad(input string name, input logic [bedm_pkg::OUT_W-1:0] want,
                                   input logic [bedm_pkg::OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    energy_report_t want;
    if (rst) begin
      window        = bedm_pkg::WINDOW_RESET;
      save_delta    = bedm_pkg::DELTA_RESET;
      save_interval = bedm_pkg::INTERVAL_RESET;
      chg_total     = '0;
      dis_total     = '0;
      chg_session   = '0;
      dis_session   = '0;
      chg_base      = '0;
      dis_base      = '0;
      dir           = bedm_pkg::DIR_STANDBY;
      save_armed    = 1'b0;
      last_check    = '0;
      report_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {bedm_pkg::REG_WINDOW, 3'b000}:   window        = pwdata[19:0];
          {bedm_pkg::REG_DELTA, 3'b000}:    save_delta    = pwdata[47:0];
          {bedm_pkg::REG_INTERVAL, 3'b000}: save_interval = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_sample(cmd, current_ma, voltage_mv, time_s);
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: result transaction with no expectation waiting", $time);
          n_err++;
        end else begin
          want = report_q.pop_front();
          n_err += field_bad("total_charge_uj", want.chg_total, total_charge_uj);
          n_err += field_bad("total_discharge_uj", want.dis_total, total_discharge_uj);
          n_err += field_bad("session_charge_uj", want.chg_session, session_charge_uj);
          n_err += field_bad("session_discharge_uj", want.dis_session,
                             session_discharge_uj);
          n_err += field_bad("direction_mode", bedm_pkg::OUT_W'(want.dir),
                             bedm_pkg::OUT_W'(direction_mode));
          n_err += field_bad("save_now", bedm_pkg::OUT_W'(want.save),
                             bedm_pkg::OUT_W'(save_now));
          n_chk++;
          if (save_now === 1'b1) n_save++;
        end
      end
    end
    pending <= report_q.size();
    errors  <= n_err;
    checked <= n_chk;
    saves   <= n_save;
  end

endmodule

FILE: bench/tb_battery_energy_direction_meter_top.sv
// Testbench top for the battery energy direction meter: stimulus, handshakes and verdict.
module tb_battery_energy_direction_meter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                           clk;
  logic                           rst;
  logic                           psel, penable, pwrite, pready;
  logic [bedm_pkg::ADDR_W-1:0]    paddr;
  logic [bedm_pkg::DATA_W-1:0]    pwdata, prdata;
  logic                           in_valid, in_ready, cmd;
  logic signed [20:0]             current_ma;
  logic [19:0]                    voltage_mv;
  logic [31:0]                    time_s;
  logic                           out_valid, out_ready;
  logic [bedm_pkg::OUT_W-1:0]     total_charge_uj, total_discharge_uj;
  logic [bedm_pkg::OUT_W-1:0]     session_charge_uj, session_discharge_uj;
  logic [2:0]                     direction_mode;
  logic                           save_now;

  int                             pending, errors, checked, saves;
  int                             sent = 0;
  int                             win_cfg = 1000;
  bit                             quiet = 1'b0;
  logic [31:0]                    clock_s;

  battery_energy_direction_meter_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .current_ma(current_ma),
    .voltage_mv(voltage_mv), .time_s(time_s),
    .out_valid(out_valid), .out_ready(out_ready),
    .total_charge_uj(total_charge_uj), .total_discharge_uj(total_discharge_uj),
    .session_charge_uj(session_charge_uj), .session_discharge_uj(session_discharge_uj),
    .direction_mode(direction_mode), .save_now(save_now)
  );

  bedm_result_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .current_ma(current_ma),
    .voltage_mv(voltage_mv), .time_s(time_s),
    .out_valid(out_valid), .out_ready(out_ready),
    .total_charge_uj(total_charge_uj), .total_discharge_uj(total_discharge_uj),
    .session_charge_uj(session_charge_uj), .session_discharge_uj(session_discharge_uj),
    .direction_mode(direction_mode), .save_now(save_now),
    .pending(pending), .errors(errors), .checked(checked), .saves(saves)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // result side: random stall before each transaction
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_reading(input logic c, input int amps, input logic [19:0] mv,
                              input logic [31:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    current_ma <= amps[20:0];
    voltage_mv <= mv;
    time_s     <= t;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // hold off until every expected result is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [bedm_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int window, input logic [47:0] delta,
                            input logic [15:0] interval);
    settle();
    write_reg(bedm_pkg::REG_WINDOW, bedm_pkg::DATA_W'(window));
    write_reg(bedm_pkg::REG_DELTA, bedm_pkg::DATA_W'(delta));
    write_reg(bedm_pkg::REG_INTERVAL, bedm_pkg::DATA_W'(interval));
    win_cfg = window;
  endtask

  function automatic int pick_current(input bit charging);
    int m;
    m = win_cfg + 1 + int'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 1048575 : 4000));
    if (charging) return (m > 1048575) ? 1048575 : m;
    return (m > 1048576) ? -1048576 : -m;
  endfunction

  function automatic logic [19:0] pick_voltage();
    case ($urandom_range(0, 15))
      0:       return 20'd0;
      1:       return 20'hFFFFF;
      default: return 20'($urandom_range(0, 1048575));
    endcase
  endfunction

  task automatic advance_clock();
    case ($urandom_range(0, 31))
      0:       clock_s = $urandom;
      1, 2:    clock_s += $urandom_range(2, 70000);
      default: clock_s += 1;
    endcase
  endtask

  // mostly direction runs with random content, the rest force saves and noise
  task automatic run_phase(input int count);
    int k, run_len, kind, amps;
    bit charging;
    k = 0;
    while (k < count) begin
      quiet = ((k / 64) % 4) == 3;
      kind  = $urandom_range(0, 99);
      if (kind < 6) begin
        send_reading(1'b1, int'($urandom), 20'($urandom), $urandom);
        k++;
      end else if (kind < 18) begin
        send_reading(1'b0, int'($urandom), 20'($urandom), $urandom);
        k++;
      end else begin
        run_len  = $urandom_range(1, 24);
        charging = $urandom_range(0, 1);
        repeat (run_len) begin
          case ($urandom_range(0, 15))
            0:       amps = int'($urandom_range(0, 2 * win_cfg)) - win_cfg;
            1:       amps = pick_current(!charging);
            default: amps = pick_current(charging);
          endcase
          advance_clock();
          send_reading(1'b0, amps, pick_voltage(), clock_s);
          k++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] r64;
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    cmd        <= 1'b0;
    current_ma <= '0;
    voltage_mv <= '0;
    time_s     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed walk through the direction machine at reset settings
    send_reading(1'b1, 0, 20'd0, 32'd0);
    send_reading(1'b0, 0, 20'hFFFFF, 32'd1);
    send_reading(1'b0, 1000, 20'hFFFFF, 32'd2);
    send_reading(1'b0, 1001, 20'd500000, 32'd3);
    send_reading(1'b0, 1048575, 20'hFFFFF, 32'd4);
    send_reading(1'b0, -1001, 20'hFFFFF, 32'd5);
    send_reading(1'b0, -5000, 20'd300000, 32'd6);
    send_reading(1'b0, -1048576, 20'hFFFFF, 32'd7);
    send_reading(1'b0, 2000, 20'd400000, 32'd8);
    send_reading(1'b0, 0, 20'd400000, 32'd9);
    send_reading(1'b0, 0, 20'd400000, 32'd10);
    send_reading(1'b0, -1000, 20'd400000, 32'd11);
    send_reading(1'b0, -1001, 20'd400000, 32'd12);
    send_reading(1'b0, 500, 20'd400000, 32'd13);
    send_reading(1'b0, 1048575, 20'd0, 32'd14);
    send_reading(1'b0, 3000, 20'd700000, 32'd100);
    send_reading(1'b0, 3000, 20'd700000, 32'hFFFF_FFF0);
    send_reading(1'b0, 3000, 20'd700000, 32'd5);
    send_reading(1'b0, -3000, 20'd700000, 32'd46);
    send_reading(1'b1, -123456, 20'd777777, 32'hDEAD_BEEF);
    send_reading(1'b0, 1048575, 20'hFFFFF, 32'd47);
    clock_s = 32'd47;

    set_config(0, 48'd0, 16'd0);
    run_phase(280);
    set_config(1048575, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    run_phase(280);
    set_config(1, 48'd1, 16'd1);
    run_phase(280);
    set_config(int'(bedm_pkg::WINDOW_RESET), bedm_pkg::DELTA_RESET, bedm_pkg::INTERVAL_RESET);
    run_phase(280);
    r64 = {$urandom, $urandom};
    set_config($urandom_range(0, 50000), r64[47:0] >> $urandom_range(8, 40),
               16'($urandom_range(0, 120)));
    run_phase(280);
    r64 = {$urandom, $urandom};
    set_config($urandom_range(0, 1048575), r64[47:0], 16'($urandom));
    run_phase(280);

    settle();
    $display("Drove %0d sample and save transactions over reset and six register settings.",
             sent);
    $display("Checked %0d results field by field, %0d of them flagged a save.", checked, saves);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
